### design/brbo_pkg.sv
// ----------------------------------------------------------------------------
// brbo_pkg
// Shared types and constants for the byte ring buffer with overwrite mode.
// ----------------------------------------------------------------------------
package brbo_pkg;

    localparam int KIND_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 11;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH  = 3'd0,
        K_POP   = 3'd1,
        K_PEEK  = 3'd2,
        K_DROP  = 3'd3,
        K_CLEAR = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_OVERWRITE = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE = 1'b0,
        CFG_MODE = 1'b1
    } t_cfg_reg;

    // Per-transaction result fields known at accept time (data comes later).
    typedef struct packed {
        t_status          status;
        logic             data_valid;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] free;
    } t_ctrl_res;

endpackage

### design/byte_ring_buffer_overwrite.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite
// Byte FIFO in a circular store with configurable size and overwrite mode.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction waits in stage 1 until the output register
//   is free; pointer update and store access happen at the accepting edge.
// Throughput: one transaction per cycle while results are taken; the store has
//   one port and each operation makes at most one access to it. A stalled
//   result holds the next one in stage 1, and only then does the input stall.
// Reset: pointers and count clear synchronously, size goes to min(1024,
//   DEPTH), overwrite mode off; the byte store itself is not cleared.
module byte_ring_buffer_overwrite #(
    parameter int DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [brbo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [brbo_pkg::CNT_W-1:0]     i_cfg_data,
    // operation channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [brbo_pkg::KIND_W-1:0]    i_kind,
    input  logic [brbo_pkg::BYTE_W-1:0]    i_data_in,
    input  logic [brbo_pkg::CNT_W-1:0]     i_amount,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [brbo_pkg::BYTE_W-1:0]    o_data_out,
    output logic                           o_data_valid,
    output logic [brbo_pkg::STATUS_W-1:0]  o_status,
    output logic [brbo_pkg::CNT_W-1:0]     o_fill_level,
    output logic [brbo_pkg::CNT_W-1:0]     o_free_space
);
    import brbo_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              accept;
    logic              p1_adv;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_rdata;
    t_ctrl_res         ctrl_res;

    // Stage 1: holds the control result while the store read completes.
    logic              r_p1_valid;
    t_ctrl_res         r_p1_res;

    // Stage 2: output register.
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    t_ctrl_res         r_out_res;

    // Configuration is always taken; user keeps the ring idle (unchecked).
    assign o_cfg_ready = 1'b1;

    // Advance stage 1 into the output register whenever that slot frees up.
    assign p1_adv     = r_p1_valid & (~r_out_valid | ~i_out_stall);
    // Hold the input only when stage 1 is occupied and cannot move on; the
    // store read data stays put because no new read issues meanwhile.
    assign o_in_stall = r_p1_valid & ~p1_adv;
    assign accept     = i_in_valid & ~o_in_stall;

    brbo_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op_en     (accept),
        .i_kind      (i_kind),
        .i_amount    (i_amount),
        .o_mem_wr_en (mem_wr_en),
        .o_mem_rd_en (mem_rd_en),
        .o_mem_addr  (mem_addr),
        .o_res       (ctrl_res)
    );

    // A push writes at one edge and a later pop reads at a later edge, so the
    // single port never sees a read and a write to the same slot together.
    brbo_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr_en (mem_wr_en),
        .i_rd_en (mem_rd_en),
        .i_addr  (mem_addr),
        .i_wdata (i_data_in),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (accept) begin
            r_p1_valid <= 1'b1;
        end else if (p1_adv) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_res <= ctrl_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Drop the read data into the result only for pop and peek hits.
    always_ff @(posedge i_clk) begin
        if (p1_adv) begin
            r_out_res  <= r_p1_res;
            r_out_data <= r_p1_res.data_valid ? mem_rdata : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_data_valid = r_out_res.data_valid;
    assign o_status     = r_out_res.status;
    assign o_fill_level = r_out_res.fill;
    assign o_free_space = r_out_res.free;

    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.data_valid) |-> (r_out_res.status == ST_OK))
        else $error("byte delivered with a non-ok status");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_res.data_valid) |-> (r_out_data == '0))
        else $error("data not zero without a byte");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && r_out_valid && i_out_stall) |-> !accept)
        else $error("transaction accepted over a blocked stage");

    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !p1_adv) |=> $stable(mem_rdata))
        else $error("store read data changed under a held stage");

endmodule

### design/brbo_ram.sv
// ----------------------------------------------------------------------------
// brbo_ram
// Single-port byte store with registered read.
// ----------------------------------------------------------------------------
module brbo_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_addr,
    input  logic [brbo_pkg::BYTE_W-1:0] i_wdata,
    output logic [brbo_pkg::BYTE_W-1:0] o_rdata
);
    import brbo_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/brbo_ctrl.sv
// ----------------------------------------------------------------------------
// brbo_ctrl
// Ring pointers, fill count and configuration; decodes each operation into
// its status and at most one store access.
// ----------------------------------------------------------------------------
module brbo_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [brbo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [brbo_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic                           i_op_en,
    input  logic [brbo_pkg::KIND_W-1:0]    i_kind,
    input  logic [brbo_pkg::CNT_W-1:0]     i_amount,
    output logic                           o_mem_wr_en,
    output logic                           o_mem_rd_en,
    output logic [AW-1:0]                  o_mem_addr,
    output brbo_pkg::t_ctrl_res            o_res
);
    import brbo_pkg::*;

    localparam int SW      = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int RST_EFF = (DEPTH < 1024) ? DEPTH : 1024;

    logic [AW-1:0]    r_rd, n_rd;
    logic [AW-1:0]    r_wr, n_wr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_eff, n_eff;
    logic             r_ow;

    logic [SW-1:0]    cfg_size;
    logic [SW-1:0]    s_ext;
    logic [SW-1:0]    wr_plus1;
    logic [SW-1:0]    rd_plus1;
    logic [AW-1:0]    wr_inc;
    logic [AW-1:0]    rd_inc;
    logic [CNT_W-1:0] drop_n;
    logic [CNT_W-1:0] ofs;
    logic [SW-1:0]    rd_sum;
    logic [SW-1:0]    rd_wrap;
    logic             full;
    logic             empty;
    t_status          status;
    logic             dvalid;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    addr;

    // Clamp the requested size into 1..DEPTH.
    assign cfg_size = SW'(i_cfg_data);
    always_comb begin
        if (cfg_size == '0) begin
            n_eff = CNT_W'(1);
        end else if (cfg_size > SW'(DEPTH)) begin
            n_eff = CNT_W'(DEPTH);
        end else begin
            n_eff = i_cfg_data;
        end
    end

    assign s_ext    = SW'(r_eff);
    assign wr_plus1 = SW'(r_wr) + SW'(1);
    assign rd_plus1 = SW'(r_rd) + SW'(1);
    assign wr_inc   = (wr_plus1 == s_ext) ? '0 : wr_plus1[AW-1:0];
    assign rd_inc   = (rd_plus1 == s_ext) ? '0 : rd_plus1[AW-1:0];
    assign drop_n   = (i_amount < r_count) ? i_amount : r_count;
    assign ofs      = (t_kind'(i_kind) == K_PEEK) ? i_amount : drop_n;
    // Where the result is used, index plus offset stays below twice the size, so one subtract wraps it.
    assign rd_sum   = SW'(r_rd) + SW'(ofs);
    assign rd_wrap  = (rd_sum >= s_ext) ? rd_sum - s_ext : rd_sum;
    assign full     = (r_count == r_eff);
    assign empty    = (r_count == '0);

    always_comb begin
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_count = r_count;
        status  = ST_OK;
        dvalid  = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        addr    = r_rd;
        unique case (t_kind'(i_kind))
            K_PUSH: begin
                addr = r_wr;
                if (!full) begin
                    wr_en   = 1'b1;
                    n_wr    = wr_inc;
                    n_count = r_count + CNT_W'(1);
                end else if (r_ow) begin
                    wr_en  = 1'b1;
                    n_wr   = wr_inc;
                    n_rd   = rd_inc;
                    status = ST_OVERWRITE;
                end else begin
                    status = ST_FULL;
                end
            end
            K_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    dvalid  = 1'b1;
                    n_rd    = rd_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            K_PEEK: begin
                addr = rd_wrap[AW-1:0];
                if (empty) begin
                    status = ST_EMPTY;
                end else if (i_amount >= r_count) begin
                    status = ST_RANGE;
                end else begin
                    rd_en  = 1'b1;
                    dvalid = 1'b1;
                end
            end
            K_DROP: begin
                if (i_amount != '0) begin
                    if (empty) begin
                        status = ST_EMPTY;
                    end else begin
                        n_rd    = rd_wrap[AW-1:0];
                        n_count = r_count - drop_n;
                    end
                end
            end
            K_CLEAR: begin
                n_rd    = '0;
                n_wr    = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
            r_eff   <= CNT_W'(RST_EFF);
            r_ow    <= 1'b0;
        end else if (i_cfg_we) begin
            if (t_cfg_reg'(i_cfg_index) == CFG_SIZE) begin
                r_eff   <= n_eff;
                r_rd    <= '0;
                r_wr    <= '0;
                r_count <= '0;
            end else begin
                r_ow <= i_cfg_data[0];
            end
        end else if (i_op_en) begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

    assign o_mem_wr_en      = i_op_en & wr_en;
    assign o_mem_rd_en      = i_op_en & rd_en;
    assign o_mem_addr       = addr;
    assign o_res.status     = status;
    assign o_res.data_valid = dvalid;
    assign o_res.fill       = n_count;
    assign o_res.free       = r_eff - n_count;

    a_count_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_eff)
        else $error("fill count exceeds ring size");

    a_rd_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_rd) < r_eff)
        else $error("read index outside ring");

    a_wr_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_wr) < r_eff)
        else $error("write index outside ring");

endmodule

### bench/byte_ring_buffer_overwrite_tb.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite_tb
// Self-checking bench for the byte ring buffer with overwrite mode. A
// predictor of the ring, with its own byte store, indices and configuration,
// works out the result of every accepted operation. Each returned result is
// compared field by field with the oldest prediction. Stimulus is a short
// directed run, then one deep fill of a mid-size ring, then random phases
// under changing size and mode settings.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brbo_pkg::*;

    localparam int RING_DEPTH  = 1024;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int DEEP_SIZE   = 160;    // ring size for the deep fill
    localparam int LONG_HOLD   = 60;     // receiver hold-off used to back up the pipe
    localparam int DRAIN_LIMIT = 4000;   // cycles to wait for outstanding results
    localparam int RANDOM_OPS  = 400;
    localparam int QUIET_AFTER = 330;    // random ops after which all idling stops

    // Kind codes the block does not define; they must act as a no-op.
    localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              dv;
        t_status           st;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  room;
    } t_ring_result;

    // ------------------------------------------------------------------------
    // Ring predictor and result scoreboard
    // ------------------------------------------------------------------------
    class t_ring_checker;
        logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
        logic [CNT_W-1:0]  size_reg;
        logic              overwrite_en;
        int unsigned       rd_idx;
        int unsigned       wr_idx;
        int unsigned       held;
        t_ring_result      pending_results [$];
        int                failures;
        int                reported;

        function new();
            size_reg     = CNT_W'(RING_DEPTH);
            overwrite_en = 1'b0;
            failures     = 0;
            reported     = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            rd_idx = 0;
            wr_idx = 0;
            held   = 0;
        endfunction

        // Size 0 behaves as 1, anything above the depth as the depth.
        function int unsigned ring_size();
            if (size_reg == 0) return 1;
            if (size_reg > RING_DEPTH) return RING_DEPTH;
            return size_reg;
        endfunction

        function int unsigned bytes_held();
            return held;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
            if (idx == CFG_SIZE) begin
                size_reg = val;
                empty_ring();
            end else begin
                overwrite_en = val[0];
            end
        endfunction

        function void note_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] din,
                              logic [CNT_W-1:0] amt);
            t_ring_result want;
            int unsigned  s;
            int unsigned  n;
            s         = ring_size();
            want.data = '0;
            want.dv   = 1'b0;
            want.st   = ST_OK;
            case (kind)
                K_PUSH: begin
                    if (held < s) begin
                        ring_bytes[IDX_W'(wr_idx)] = din;
                        wr_idx = (wr_idx + 1) % s;
                        held++;
                    end else if (overwrite_en) begin
                        ring_bytes[IDX_W'(wr_idx)] = din;
                        wr_idx  = (wr_idx + 1) % s;
                        rd_idx  = (rd_idx + 1) % s;
                        want.st = ST_OVERWRITE;
                    end else begin
                        want.st = ST_FULL;
                    end
                end
                K_POP: begin
                    if (held == 0) begin
                        want.st = ST_EMPTY;
                    end else begin
                        want.data = ring_bytes[IDX_W'(rd_idx)];
                        want.dv   = 1'b1;
                        rd_idx    = (rd_idx + 1) % s;
                        held--;
                    end
                end
                K_PEEK: begin
                    if (held == 0) begin
                        want.st = ST_EMPTY;
                    end else if (amt >= held) begin
                        want.st = ST_RANGE;
                    end else begin
                        want.data = ring_bytes[IDX_W'((rd_idx + amt) % s)];
                        want.dv   = 1'b1;
                    end
                end
                K_DROP: begin
                    if (amt != 0) begin
                        if (held == 0) begin
                            want.st = ST_EMPTY;
                        end else begin
                            n      = (amt < held) ? amt : held;
                            rd_idx = (rd_idx + n) % s;
                            held   = held - n;
                        end
                    end
                end
                K_CLEAR: empty_ring();
                default: ;
            endcase
            want.fill = CNT_W'(held);
            want.room = CNT_W'(s - held);
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic dv, logic [STATUS_W-1:0] st,
                                   logic [CNT_W-1:0] fill, logic [CNT_W-1:0] room);
            t_ring_result want;
            if (pending_results.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("[%0t] result with nothing outstanding: data=%0d dv=%0d st=%0d",
                             $time, data, dv, st);
                end
                return;
            end
            want = pending_results.pop_front();
            if (data !== want.data || dv !== want.dv || st !== want.st ||
                fill !== want.fill || room !== want.room) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("[%0t] mismatch: expected data=%0d dv=%0d st=%0d fill=%0d free=%0d",
                             $time, want.data, want.dv, want.st, want.fill, want.room);
                    $display("             actual   data=%0d dv=%0d st=%0d fill=%0d free=%0d",
                             data, dv, st, fill, room);
                end
            end
        endfunction

        function void flag_leftovers();
            if (pending_results.size() != 0) begin
                failures += pending_results.size();
                $display("%0d expected results never arrived", pending_results.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench state
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SIZE;
    logic [CNT_W-1:0]      i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind      = K_PUSH;
    logic [BYTE_W-1:0]     i_data_in   = '0;
    logic [CNT_W-1:0]      i_amount    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BYTE_W-1:0]     o_data_out;
    logic                  o_data_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [CNT_W-1:0]      o_fill_level;
    logic [CNT_W-1:0]      o_free_space;

    t_ring_checker ring_model = new();

    // Shared between the operation sender and the result receiver. Both are
    // written with nonblocking assignments and read at the falling edge.
    logic quiet     = 1'b0;   // no idling on either side from here on
    int   hold_asks = 0;      // bumped to ask the receiver for one long hold-off
    int   send_idle_pct;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    byte_ring_buffer_overwrite #(
        .DEPTH(RING_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_data_in   (i_data_in),
        .i_amount    (i_amount),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_data_valid(o_data_valid),
        .o_status    (o_status),
        .o_fill_level(o_fill_level),
        .o_free_space(o_free_space)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge. Check the result
    // first, then apply register writes and operations to the predictor in
    // the order the block sees them.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                ring_model.check_result(o_data_out, o_data_valid, o_status,
                                        o_fill_level, o_free_space);
            if (i_cfg_valid && o_cfg_ready)
                ring_model.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                ring_model.note_op(i_kind, i_data_in, i_amount);
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stall bursts, a stall rate redrawn among three
    // settings (zero included), and one long hold-off
    // per request so the pipe backs up and stalls the operation channel.
    // ------------------------------------------------------------------------
    initial begin
        int burst;
        int holds_served;
        int cycle_cnt;
        int stall_pct;
        burst        = 0;
        holds_served = 0;
        cycle_cnt    = 0;
        stall_pct    = 20;
        forever begin
            @(negedge i_clk);
            cycle_cnt++;
            if (cycle_cnt % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            if (hold_asks != holds_served) begin
                holds_served++;
                burst = LONG_HOLD;
            end else if (burst == 0 && !quiet && $urandom_range(0, 99) < stall_pct) begin
                burst = $urandom_range(1, 6);
            end
            i_out_stall <= (burst > 0);
            if (burst > 0) burst--;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Every task starts its drive at a falling edge, so each
    // input sees at most one assignment per time step.
    // ------------------------------------------------------------------------

    // Hold the current transaction on the channel until it is taken.
    task automatic offer_op(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] din,
                            input logic [CNT_W-1:0] amt);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_data_in  <= din;
        i_amount   <= amt;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid for a random burst; called right after a falling edge.
    task automatic sender_idle();
        int gap;
        if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] din,
                           input logic [CNT_W-1:0] amt);
        @(negedge i_clk);
        sender_idle();
        offer_op(kind, din, amt);
    endtask

    // Pick an operation from the predicted fill level, which is stable at the
    // falling edge. Peeks mostly land at most one past the fill level and drops are
    // mostly short, with full-range offsets mixed in.
    task automatic send_random(input int push_bias);
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] din;
        logic [CNT_W-1:0]  amt;
        int unsigned       held;
        int                pick;
        @(negedge i_clk);
        sender_idle();
        held = ring_model.bytes_held();
        din  = BYTE_W'($urandom);
        amt  = CNT_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 99) < push_bias) begin
            kind = K_PUSH;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                kind = K_POP;
            end else if (pick < 65) begin
                kind = K_PEEK;
                if ($urandom_range(0, 4) != 0) amt = CNT_W'($urandom_range(0, held + 1));
            end else if (pick < 85) begin
                kind = K_DROP;
                if ($urandom_range(0, 3) != 0) amt = CNT_W'($urandom_range(0, 3));
            end else if (pick < 92) begin
                kind = K_CLEAR;
            end else begin
                kind = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
            end
        end
        offer_op(kind, din, amt);
    endtask

    // Pause the sender until every predicted result is back or DRAIN_LIMIT runs
    // out, then let the pipe settle.
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (ring_model.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Registers change only with the block idle.
    task automatic set_config(input logic [CNT_W-1:0] size, input logic mode);
        drain();
        cfg_write(CFG_SIZE, size);
        cfg_write(CFG_MODE, CNT_W'(mode));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned       random_ops;
        int unsigned       phase;
        int unsigned       phase_len;
        int                bias;
        logic [CNT_W-1:0]  size_val;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 20;

        // Directed: a four-byte ring walked through empty, full, refused and
        // out-of-range cases, unknown kinds, then a mode change that keeps
        // the contents and turns the next full push into an overwrite.
        set_config(4, 1'b0);
        send_op(K_POP,   8'h00, 0);
        send_op(K_PEEK,  8'h00, 0);
        send_op(K_DROP,  8'h00, 1);
        send_op(K_DROP,  8'hFF, 0);      // zero-length drop on an empty ring
        send_op(K_PUSH,  8'h00, 2047);
        send_op(K_PUSH,  8'hFF, 0);
        send_op(K_PUSH,  8'hA5, 0);
        send_op(K_PUSH,  8'h5A, 0);
        send_op(K_PUSH,  8'h3C, 0);      // refused, ring is full
        send_op(K_PEEK,  8'h00, 3);
        send_op(K_PEEK,  8'h00, 4);      // offset equal to fill level
        send_op(K_PEEK,  8'h00, 2047);
        send_op(KIND_RSVD_LO, 8'hFF, 2047);
        send_op(KIND_RSVD_HI, 8'h00, 0);
        send_op(K_POP,   8'h00, 0);
        send_op(K_DROP,  8'h00, 2);
        send_op(K_PUSH,  8'h11, 0);
        send_op(K_PUSH,  8'h22, 0);
        send_op(K_PUSH,  8'h33, 0);
        drain();
        cfg_write(CFG_MODE, 1);
        send_op(K_PUSH,  8'h44, 0);      // oldest byte overwritten
        send_op(K_PEEK,  8'h00, 0);
        send_op(K_DROP,  8'h00, 2047);   // more than held: empties the ring
        send_op(K_PUSH,  8'h77, 0);
        send_op(K_CLEAR, 8'h00, 0);
        send_op(K_POP,   8'h00, 0);

        // Size 0 must behave as a one-byte ring.
        set_config(0, 1'b1);
        send_op(K_PUSH,  8'h01, 0);
        send_op(K_PUSH,  8'h02, 0);
        send_op(K_POP,   8'h00, 0);

        // Deep fill: fill a mid-size ring completely, push past it, peek at
        // the last slot and just beyond, then drop everything.
        set_config(CNT_W'(DEEP_SIZE), 1'($urandom_range(0, 1)));
        repeat (DEEP_SIZE + 2) send_random(100);
        send_op(K_PEEK, BYTE_W'($urandom), CNT_W'(DEEP_SIZE - 1));
        send_op(K_PEEK, BYTE_W'($urandom), CNT_W'(DEEP_SIZE));
        send_op(K_DROP, BYTE_W'($urandom), CNT_W'(DEEP_SIZE));

        // Random phases: mostly small rings so full and overwrite come often,
        // with the size extremes and out-of-range sizes mixed in.
        random_ops = 0;
        phase      = 0;
        while (random_ops < RANDOM_OPS) begin
            case ($urandom_range(0, 9))
                0:       size_val = '0;
                1:       size_val = CNT_W'(1);
                2:       size_val = CNT_W'(2047);
                3:       size_val = CNT_W'($urandom_range(RING_DEPTH + 1, 2046));
                4:       size_val = CNT_W'(RING_DEPTH);
                default: size_val = CNT_W'($urandom_range(2, 12));
            endcase
            set_config(size_val, 1'($urandom_range(0, 1)));
            phase_len = $urandom_range(40, 90);
            bias      = $urandom_range(30, 60);
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 10;
                default: send_idle_pct = 30;
            endcase
            if (phase == 0) begin
                // Keep offering back to back while the receiver holds off.
                send_idle_pct = 0;
                hold_asks <= hold_asks + 1;
            end
            for (int i = 0; i < phase_len; i++) begin
                if (i == phase_len / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
                    drain();
                send_random(bias);
                random_ops++;
                if (!quiet && random_ops >= QUIET_AFTER) quiet <= 1'b1;
            end
            phase++;
        end

        drain();
        ring_model.flag_leftovers();
        if (ring_model.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
